FILE: src/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Used by the channel interfaces, the free stack and the top level.
package gha_pkg;

  // widths of the item fields on the channels
  localparam int unsigned IDX_FIELD_W = 10;
  localparam int unsigned GEN_FIELD_W = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_DESTROY = 2'd1,
    OP_RESOLVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_FIN
  } state_e;

  // control from the sequencer to the free stack
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } stk_ctrl_t;

  // status from the free stack
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  // one result item
  typedef struct packed {
    logic [1:0]             status;
    logic [IDX_FIELD_W-1:0] slot_index;
    logic [GEN_FIELD_W-1:0] slot_generation;
    logic                   invalidate_handle;
  } rsp_t;

endpackage

FILE: src/gha_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// Depends on gha_pkg for the field widths.
interface gha_req_if;
  import gha_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [IDX_FIELD_W-1:0] handle_index;
  logic [GEN_FIELD_W-1:0] handle_generation;

  modport source (output valid, operation, handle_index, handle_generation, input ready);
  modport sink   (input valid, operation, handle_index, handle_generation, output ready);
endinterface

FILE: src/gha_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on gha_pkg for the field widths.
interface gha_rsp_if;
  import gha_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [IDX_FIELD_W-1:0] slot_index;
  logic [GEN_FIELD_W-1:0] slot_generation;
  logic                   invalidate_handle;

  modport source (output valid, status, slot_index, slot_generation, invalidate_handle,
                  input ready);
  modport sink   (input valid, status, slot_index, slot_generation, invalidate_handle,
                  output ready);
endinterface

FILE: src/gha_free_stack.sv
// LIFO of freed slot indices held in a synchronous memory, with its fill count.
// Depends on gha_pkg for the control and status structs.
module gha_free_stack #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gha_pkg::stk_ctrl_t            ctrl_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] push_idx_i,
  output logic [$clog2(SLOT_COUNT)-1:0] top_o,
  output gha_pkg::stk_stat_t            stat_o
);
  import gha_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = IdxW + 1;

  logic [IdxW-1:0] stk_mem [SLOT_COUNT];
  logic [IdxW-1:0] top_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_m1;

  assign count_m1      = count_q - CntW'(1);
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.full   = (count_q == CntW'(SLOT_COUNT));
  assign top_o         = top_q;

  // fill count: pop and push never come together
  always_comb begin
    count_d = count_q;
    if (ctrl_i.pop && !stat_o.empty) begin
      count_d = count_m1;
    end else if (ctrl_i.push && !stat_o.full) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // registered top-of-stack read; push writes at the fill count
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !stat_o.full) begin
      stk_mem[count_q[IdxW-1:0]] <= push_idx_i;
    end
    if (ctrl_i.rd) begin
      top_q <= stk_mem[count_m1[IdxW-1:0]];
    end
  end

endmodule

FILE: src/generational_handle_allocator_core.sv
// Generational handle allocator: slot table of {in use, generation} in one
// synchronous memory, free stack in a second. One item in flight at a time.
// A request goes from S_IDLE to S_FIN, through S_POP for an allocate served
// from the free stack (stack read, then table read), as the memory reads are
// registered; S_FIN waits for a free result register, which holds the result.
// Reset clears counters and control at once; the high-water mark tells which
// table entries are written, so no clearing pass runs.
module generational_handle_allocator_core #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned GEN_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);
  import gha_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CmpW = ((IdxW > IDX_FIELD_W) ? IdxW : IDX_FIELD_W) + 1;

  state_e state_q, state_d;

  // captured request
  logic [1:0]             op_q;
  logic [IDX_FIELD_W-1:0] idx_q;
  logic [GEN_FIELD_W-1:0] gen_q;

  logic [CntW-1:0] hw_q, hw_d;
  rsp_t            rsp_q, rsp_d;
  logic            out_vld_q, out_vld_d;
  logic            out_free;
  logic            accept;

  // slot table memory
  logic [GEN_BITS:0]   tbl_mem [SLOT_COUNT];
  logic [GEN_BITS:0]   tbl_rdata_q;
  logic                tbl_re, tbl_we;
  logic [IdxW-1:0]     tbl_raddr, tbl_waddr;
  logic [GEN_BITS:0]   tbl_wdata;

  // free stack
  stk_ctrl_t       stk_ctrl;
  stk_stat_t       stk_stat;
  logic [IdxW-1:0] stk_top;

  // width conversions
  logic [IdxW+IDX_FIELD_W-1:0]     req_idx_wide, idx_q_wide;
  logic [IdxW-1:0]                 req_idx_a, idx_a;
  logic [GEN_BITS+GEN_FIELD_W-1:0] gen_q_wide;
  logic [GEN_BITS-1:0]             gen_cmp;
  logic [IdxW-1:0]                 res_slot;
  logic [GEN_BITS-1:0]             res_gen;
  logic [IdxW+IDX_FIELD_W-1:0]     res_slot_wide;
  logic [GEN_BITS+GEN_FIELD_W-1:0] res_gen_wide;

  // handle check
  logic               req_in_range;
  logic               live;
  logic               entry_used;
  logic [GEN_BITS-1:0] entry_gen;
  logic               handle_ok;

  gha_free_stack #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (stk_ctrl),
    .push_idx_i (idx_a),
    .top_o      (stk_top),
    .stat_o     (stk_stat)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;

  assign req_idx_wide = {{IdxW{1'b0}}, req_i.handle_index};
  assign req_idx_a    = req_idx_wide[IdxW-1:0];
  assign idx_q_wide   = {{IdxW{1'b0}}, idx_q};
  assign idx_a        = idx_q_wide[IdxW-1:0];
  assign gen_q_wide   = {{GEN_BITS{1'b0}}, gen_q};
  assign gen_cmp      = gen_q_wide[GEN_BITS-1:0];

  assign req_in_range = CmpW'(req_i.handle_index) < CmpW'(SLOT_COUNT);
  // an index below the high-water mark is in range and its entry is written
  assign live         = CmpW'(idx_q) < CmpW'(hw_q);
  assign entry_used   = tbl_rdata_q[GEN_BITS];
  assign entry_gen    = tbl_rdata_q[GEN_BITS-1:0];
  assign handle_ok    = live && entry_used && (gen_cmp == entry_gen);

  assign res_slot_wide = {{IDX_FIELD_W{1'b0}}, res_slot};
  assign res_gen_wide  = {{GEN_FIELD_W{1'b0}}, res_gen};

  // sequencer: issue reads, then decide, write back and load the result
  always_comb begin
    state_d   = state_q;
    hw_d      = hw_q;
    rsp_d     = rsp_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    tbl_re    = 1'b0;
    tbl_raddr = req_idx_a;
    tbl_we    = 1'b0;
    tbl_waddr = idx_a;
    tbl_wdata = {1'b0, entry_gen + GEN_BITS'(1)};
    stk_ctrl  = '0;
    res_slot  = '0;
    res_gen   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FIN;
          case (req_i.operation)
            OP_ALLOC: begin
              if (!stk_stat.empty) begin
                stk_ctrl.rd = 1'b1;
                state_d     = S_POP;
              end
            end
            OP_DESTROY, OP_RESOLVE: begin
              tbl_re = req_in_range;
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        tbl_re    = 1'b1;
        tbl_raddr = stk_top;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          state_d   = S_IDLE;
          out_vld_d = 1'b1;
          rsp_d     = '0;
          case (op_q)
            OP_ALLOC: begin
              if (!stk_stat.empty) begin
                // reuse the most recently freed slot, keeping its generation
                stk_ctrl.pop = 1'b1;
                res_slot     = stk_top;
                res_gen      = entry_gen;
                tbl_we       = 1'b1;
                tbl_waddr    = stk_top;
                tbl_wdata    = {1'b1, entry_gen};
              end else if (hw_q < CntW'(SLOT_COUNT)) begin
                // first use of a fresh slot, generation zero
                res_slot  = hw_q[IdxW-1:0];
                tbl_we    = 1'b1;
                tbl_waddr = hw_q[IdxW-1:0];
                tbl_wdata = {1'b1, {GEN_BITS{1'b0}}};
                hw_d      = hw_q + CntW'(1);
              end
              if (!stk_stat.empty || hw_q < CntW'(SLOT_COUNT)) begin
                rsp_d.status          = ST_OK;
                rsp_d.slot_index      = res_slot_wide[IDX_FIELD_W-1:0];
                rsp_d.slot_generation = res_gen_wide[GEN_FIELD_W-1:0];
              end else begin
                rsp_d.status = ST_FULL;
              end
            end
            OP_DESTROY: begin
              rsp_d.invalidate_handle = 1'b1;
              if (handle_ok) begin
                // bump generation, mark free, push the index
                tbl_we        = 1'b1;
                stk_ctrl.push = 1'b1;
                rsp_d.status  = ST_OK;
              end else begin
                rsp_d.status = ST_INVALID;
              end
            end
            OP_RESOLVE: begin
              if (handle_ok) begin
                res_gen               = entry_gen;
                rsp_d.status          = ST_OK;
                rsp_d.slot_index      = idx_q;
                rsp_d.slot_generation = res_gen_wide[GEN_FIELD_W-1:0];
              end else begin
                rsp_d.status            = ST_INVALID;
                rsp_d.invalidate_handle = 1'b1;
              end
            end
            default: begin
              rsp_d.status = ST_INVALID;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hw_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hw_q      <= hw_d;
      out_vld_q <= out_vld_d;
    end
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.operation;
      idx_q <= req_i.handle_index;
      gen_q <= req_i.handle_generation;
    end
    rsp_q <= rsp_d;
  end

  // slot table: one read and one write port, read data registered
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.status            = rsp_q.status;
  assign rsp_o.slot_index        = rsp_q.slot_index;
  assign rsp_o.slot_generation   = rsp_q.slot_generation;
  assign rsp_o.invalidate_handle = rsp_q.invalidate_handle;

endmodule

FILE: verif/gha_slot_checker.sv
// Checker for the generational handle allocator: watches both channels,
// keeps its own copy of the slot table and compares every result item.
// Depends on gha_pkg and the gha_req_if / gha_rsp_if channel interfaces.
module gha_slot_checker
  import gha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gha_req_if   req,
  gha_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);

  localparam int unsigned SLOTS = 1 << IDX_FIELD_W;
  localparam int unsigned MAX_REPORTS = 50;

  // shadow slot table and free stack
  logic [GEN_FIELD_W-1:0] slot_gen   [SLOTS];
  bit                     slot_busy  [SLOTS];
  logic [IDX_FIELD_W-1:0] free_slots [SLOTS];
  int unsigned            free_depth;
  int unsigned            high_mark;

  rsp_t expected_results [$];

  // apply one request to the shadow table and return the result item it causes
  function automatic rsp_t predict_slot_op(input logic [1:0]             op,
                                           input logic [IDX_FIELD_W-1:0] idx,
                                           input logic [GEN_FIELD_W-1:0] gen);
    rsp_t                   r;
    logic [IDX_FIELD_W-1:0] slot;
    bit                     live;
    r    = '0;
    live = slot_busy[idx] && (slot_gen[idx] == gen);
    case (op)
      OP_ALLOC: begin
        if (free_depth > 0) begin
          // most recently freed slot first, generation kept
          free_depth--;
          slot            = free_slots[free_depth];
          slot_busy[slot] = 1'b1;
          r.status        = ST_OK;
          r.slot_index    = slot;
          r.slot_generation = slot_gen[slot];
        end else if (high_mark < SLOTS) begin
          // fresh slot starts at generation zero
          slot            = IDX_FIELD_W'(high_mark);
          high_mark++;
          slot_gen[slot]  = '0;
          slot_busy[slot] = 1'b1;
          r.status        = ST_OK;
          r.slot_index    = slot;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        r.invalidate_handle = 1'b1;
        if (live) begin
          slot_gen[idx]          = slot_gen[idx] + 1'b1;
          slot_busy[idx]         = 1'b0;
          free_slots[free_depth] = idx;
          free_depth++;
          r.status = ST_OK;
        end else begin
          r.status = ST_INVALID;
        end
      end
      OP_RESOLVE: begin
        if (live) begin
          r.status          = ST_OK;
          r.slot_index      = idx;
          r.slot_generation = slot_gen[idx];
        end else begin
          r.status            = ST_INVALID;
          r.invalidate_handle = 1'b1;
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
      end
      fail_count++;
    end
  endtask

  // results are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 1'b0;
      end
      free_depth = 0;
      high_mark  = 0;
      fail_count = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $error("result item with nothing expected: status %0h", rsp.status);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
          check_field("slot_generation", 32'(want.slot_generation),
                      32'(rsp.slot_generation));
          check_field("invalidate_handle", 32'(want.invalidate_handle),
                      32'(rsp.invalidate_handle));
        end
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_slot_op(req.operation, req.handle_index,
                                                   req.handle_generation));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb_generational_handle_allocator_core.sv
// Testbench top for the generational handle allocator: drives requests and
// result back-pressure, gives the verdict. Depends on gha_pkg, the channel
// interfaces, gha_slot_checker and generational_handle_allocator_core.
module tb_generational_handle_allocator_core;
  import gha_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         RANDOM_ITEMS = 750;
  localparam int         STALE_KEEP  = 64;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fail_count;
  int outstanding;
  int stalled_cycles;

  // no idling at all while set
  bit calm;
  // collect handles from allocate results while set
  bit track_handles;
  int pool_cap;

  logic [1:0]             sent_ops  [$];
  logic [IDX_FIELD_W-1:0] live_idx  [$];
  logic [GEN_FIELD_W-1:0] live_gen  [$];
  logic [IDX_FIELD_W-1:0] stale_idx [$];
  logic [GEN_FIELD_W-1:0] stale_gen [$];

  gha_req_if req_ch ();
  gha_rsp_if rsp_ch ();

  generational_handle_allocator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  gha_slot_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // one request item, with a random gap in front of it
  task automatic send_req(input logic [1:0] op, input logic [IDX_FIELD_W-1:0] idx,
                          input logic [GEN_FIELD_W-1:0] gen);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid             <= 1'b1;
    req_ch.operation         <= op;
    req_ch.handle_index      <= idx;
    req_ch.handle_generation <= gen;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_ops.push_back(op);
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic alloc_noisy();
    send_req(OP_ALLOC, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
  endtask

  // destroy a known live handle and remember it as stale
  task automatic destroy_live();
    int k;
    logic [IDX_FIELD_W-1:0] idx;
    logic [GEN_FIELD_W-1:0] gen;
    k   = $urandom_range(0, live_idx.size() - 1);
    idx = live_idx[k];
    gen = live_gen[k];
    live_idx.delete(k);
    live_gen.delete(k);
    stale_idx.push_back(idx);
    stale_gen.push_back(gen);
    if (stale_idx.size() > STALE_KEEP) begin
      void'(stale_idx.pop_front());
      void'(stale_gen.pop_front());
    end
    send_req(OP_DESTROY, idx, gen);
  endtask

  task automatic resolve_live();
    int k;
    k = $urandom_range(0, live_idx.size() - 1);
    send_req(OP_RESOLVE, live_idx[k], live_gen[k]);
  endtask

  // mostly well-formed allocate / destroy / resolve traffic, some noise
  task automatic random_item();
    int r;
    int k;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      if (live_idx.size() < pool_cap || live_idx.size() == 0) alloc_noisy();
      else destroy_live();
    end else if (r < 65) begin
      if (live_idx.size() > 0) destroy_live();
      else alloc_noisy();
    end else if (r < 80) begin
      if (live_idx.size() > 0) resolve_live();
      else alloc_noisy();
    end else if (r < 88) begin
      // stale handle, or a live index with a corrupted generation
      op = ($urandom_range(0, 1) == 0) ? OP_RESOLVE : OP_DESTROY;
      if (stale_idx.size() > 0 && $urandom_range(0, 1) == 0) begin
        k = $urandom_range(0, stale_idx.size() - 1);
        send_req(op, stale_idx[k], stale_gen[k]);
      end else if (live_idx.size() > 0) begin
        k = $urandom_range(0, live_idx.size() - 1);
        send_req(op, live_idx[k],
                 live_gen[k] ^ (GEN_FIELD_W'(1) << $urandom_range(0, GEN_FIELD_W - 1)));
      end else begin
        send_req(op, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
      end
    end else if (r < 96) begin
      send_req(2'($urandom), IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
    end else begin
      send_req(OP_UNUSED, IDX_FIELD_W'($urandom), GEN_FIELD_W'($urandom));
    end
  endtask

  // learn handed-out handles from allocate results
  always @(posedge clk_i) begin
    logic [1:0] op;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (track_handles && op == OP_ALLOC && rsp_ch.status == ST_OK) begin
        live_idx.push_back(rsp_ch.slot_index);
        live_gen.push_back(rsp_ch.slot_generation);
      end
    end
  end

  // result back-pressure
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    calm          = 1'b0;
    track_handles = 1'b0;
    pool_cap      = 8;
    rst_ni                   <= 1'b0;
    req_ch.valid             <= 1'b0;
    req_ch.operation         <= OP_ALLOC;
    req_ch.handle_index      <= '0;
    req_ch.handle_generation <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, fresh slots, stale and freed handles, reuse order
    send_req(OP_RESOLVE, '0, '0);
    send_req(OP_DESTROY, '1, '1);
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_RESOLVE, 10'd0, 16'd0);
    send_req(OP_RESOLVE, 10'd1, '1);
    send_req(OP_DESTROY, 10'd0, 16'd1);
    send_req(OP_DESTROY, 10'd0, 16'd0);
    send_req(OP_RESOLVE, 10'd0, 16'd0);
    // freed slot with its current generation still fails
    send_req(OP_DESTROY, 10'd0, 16'd1);
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_RESOLVE, 10'd0, 16'd1);
    send_req(OP_DESTROY, 10'd1, 16'd0);
    send_req(OP_DESTROY, 10'd0, 16'd1);
    // last freed comes back first
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_ALLOC, '0, '0);
    send_req(OP_UNUSED, '1, '1);
    send_req(OP_UNUSED, '0, '0);
    send_req(OP_ALLOC, '1, '1);
    send_req(OP_RESOLVE, '1, '0);
    send_req(OP_RESOLVE, 10'd2, 16'd0);
    drain_results();

    // table now holds slot 0 gen 2, slot 1 gen 1, slots 2 and 3 gen 0
    live_idx = '{10'd0, 10'd1, 10'd2, 10'd3};
    live_gen = '{16'd2, 16'd1, 16'd0, 16'd0};
    track_handles = 1'b1;

    // random traffic, pool size changing now and then
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       pool_cap = 2;
          1:       pool_cap = 8;
          2:       pool_cap = 32;
          default: pool_cap = 200;
        endcase
      end
      calm = (i % 150) < 25;
      if (i == RANDOM_ITEMS / 2) drain_results();
      random_item();
    end
    calm = 1'b0;
    drain_results();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
